// ----- rtl/core/spq_pkg.sv -----
// shared types, codes and defaults for the sorted priority queue
package spq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int ELEM_BITS_DEF = 32;
  localparam int PRIO_BITS_DEF = 16;

  // port field widths
  localparam int REQ_W   = 2;
  localparam int ELEM_W  = 32;
  localparam int PRIO_W  = 16;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // request codes (any other code acts as a peek)
  localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              exec;
    op_t               op;
    logic [STAT_W-1:0] code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             full;
    logic             empty;
  } stat_t;

endpackage

// ----- rtl/core/spq_dpath.sv -----
// datapath of the sorted priority queue: request latch, sorted slot row, result register
module spq_dpath #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int ELEM_BITS = spq_pkg::ELEM_BITS_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [spq_pkg::REQ_W-1:0]    req_in,
  input  logic [spq_pkg::ELEM_W-1:0]   elem_in,
  input  logic [spq_pkg::PRIO_W-1:0]   prio_in,
  input  spq_pkg::cmd_t                cmd,
  output spq_pkg::stat_t               st,
  output logic [spq_pkg::ELEM_W-1:0]   head_elem,
  output logic [spq_pkg::PRIO_W-1:0]   head_prio,
  output logic                         is_empty,
  output logic [spq_pkg::COUNT_W-1:0]  count,
  output logic [spq_pkg::STAT_W-1:0]   status
);

  localparam int CW = $clog2(CAPACITY + 1);

  // latched request
  logic [spq_pkg::REQ_W-1:0] req_q;
  logic [ELEM_BITS-1:0]      elem_q;
  logic [PRIO_BITS-1:0]      prio_q;

  logic [63:0] elem_wide_in;
  logic [31:0] prio_wide_in;

  assign elem_wide_in = 64'(elem_in);
  assign prio_wide_in = 32'(prio_in);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req_in;
      elem_q <= elem_wide_in[ELEM_BITS-1:0];
      prio_q <= prio_wide_in[PRIO_BITS-1:0];
    end
  end

  // sorted slot row, head at index 0
  logic [ELEM_BITS-1:0] slot_elem      [CAPACITY];
  logic [PRIO_BITS-1:0] slot_prio      [CAPACITY];
  logic [ELEM_BITS-1:0] slot_elem_next [CAPACITY];
  logic [PRIO_BITS-1:0] slot_prio_next [CAPACITY];
  logic [CAPACITY-1:0]  shift;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        fill_next;

  assign st.req   = req_q;
  assign st.full  = (fill == CW'(CAPACITY));
  assign st.empty = (fill == '0);

  // a slot moves down when it is empty or holds a strictly larger priority
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      shift[i] = (CW'(i) >= fill) || (slot_prio[i] > prio_q);
    end
  end

  always_comb begin
    fill_next = fill;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_elem_next[i] = slot_elem[i];
      slot_prio_next[i] = slot_prio[i];
    end
    case (cmd.op)
      spq_pkg::OP_PUSH: begin
        fill_next = fill + 1'b1;
        for (int i = 0; i < CAPACITY; i++) begin
          if (shift[i]) begin
            if (i > 0 && shift[(i > 0) ? i - 1 : 0]) begin
              slot_elem_next[i] = slot_elem[(i > 0) ? i - 1 : 0];
              slot_prio_next[i] = slot_prio[(i > 0) ? i - 1 : 0];
            end else begin
              slot_elem_next[i] = elem_q;
              slot_prio_next[i] = prio_q;
            end
          end
        end
      end
      spq_pkg::OP_POP: begin
        fill_next = fill - 1'b1;
        for (int i = 0; i < CAPACITY - 1; i++) begin
          slot_elem_next[i] = slot_elem[i + 1];
          slot_prio_next[i] = slot_prio[i + 1];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.exec) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slot_elem[i] <= slot_elem_next[i];
        slot_prio[i] <= slot_prio_next[i];
      end
    end
  end

  // result register, describes the head after the operation
  logic [63:0] head_elem_wide;
  logic [31:0] head_prio_wide;
  logic [31:0] fill_wide;
  logic        empty_next;

  assign head_elem_wide = 64'(slot_elem_next[0]);
  assign head_prio_wide = 32'(slot_prio_next[0]);
  assign fill_wide      = 32'(fill_next);
  assign empty_next     = (fill_next == '0);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      head_elem <= empty_next ? '0 : head_elem_wide[spq_pkg::ELEM_W-1:0];
      head_prio <= empty_next ? '0 : head_prio_wide[spq_pkg::PRIO_W-1:0];
      is_empty  <= empty_next;
      count     <= fill_wide[spq_pkg::COUNT_W-1:0];
      status    <= cmd.code;
    end
  end

endmodule

// ----- rtl/core/spq_ctrl.sv -----
// controller of the sorted priority queue: request sequencing and output handshake
module spq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  spq_pkg::stat_t st,
  output spq_pkg::cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd.load = s_tvalid && (state == S_IDLE);
    cmd.exec = (state == S_EXEC) && out_free;
    cmd.op   = spq_pkg::OP_HOLD;
    cmd.code = spq_pkg::ST_OK;
    case (st.req)
      spq_pkg::REQ_ENQ: begin
        if (st.full) begin
          cmd.code = spq_pkg::ST_FULL;
        end else begin
          cmd.op = spq_pkg::OP_PUSH;
        end
      end
      spq_pkg::REQ_DEQ: begin
        if (st.empty) begin
          cmd.code = spq_pkg::ST_EMPTY;
        end else begin
          cmd.op = spq_pkg::OP_POP;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.exec) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == spq_pkg::OP_PUSH) |-> !st.full)
    else $error("push issued on a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == spq_pkg::OP_POP) |-> !st.empty)
    else $error("pop issued on an empty queue");

  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_EXEC) && !s_tready)
    else $error("accepted request not held for execution");

  a_result_drains: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !cmd.exec) |=> !m_tvalid)
    else $error("result repeated after transfer");

  a_exec_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> m_tvalid)
    else $error("executed request produced no result");
`endif

endmodule

// ----- rtl/core/sorted_priority_queue_unit.sv -----
// top level of the bounded sorted priority queue
//
// channel   dir  tdata (low bit up)                         tuser
// s_axis    in   elem_in[31:0], prio_in[47:32]              req_type[1:0]
// m_axis    out  head_elem[31:0], head_prio[47:32],         none
//                is_empty[48], count[53:49], status[55:54]
//
// each request is latched in S_IDLE, then S_EXEC updates the sorted
// slot row and loads the result register; the slot row updates every entry
// in parallel, so the time taken does not depend on the fill level
// a new request is taken while the previous result still waits on m_axis;
// execution waits only when that result has not been transferred yet
// rst is synchronous: the queue comes up empty, slot contents are unknown
module sorted_priority_queue_unit #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int ELEM_BITS = spq_pkg::ELEM_BITS_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // elem_in[31:0], prio_in[47:32]
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata   // head_elem, head_prio, is_empty, count, status
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t st;

  // result fields
  logic [spq_pkg::ELEM_W-1:0]  head_elem;
  logic [spq_pkg::PRIO_W-1:0]  head_prio;
  logic                        is_empty;
  logic [spq_pkg::COUNT_W-1:0] count;
  logic [spq_pkg::STAT_W-1:0]  status;

  // sequencing and handshake
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // sorted storage and result register
  spq_dpath #(
    .CAPACITY  (CAPACITY),
    .ELEM_BITS (ELEM_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_in    (s_tuser),
    .elem_in   (s_tdata[31:0]),
    .prio_in   (s_tdata[47:32]),
    .cmd       (cmd),
    .st        (st),
    .head_elem (head_elem),
    .head_prio (head_prio),
    .is_empty  (is_empty),
    .count     (count),
    .status    (status)
  );

  // pack the result transfer, fields from the low bit up
  assign m_tdata = {status, count, is_empty, head_prio, head_elem};

endmodule
